/* rtl/irn_pkg.sv */
// irn_pkg: shared types and constants for the nearest-neighbor sprite rotator
// used by irn_front, irn_queue, irn_back and image_rotate_nearest_unit
`default_nettype none

package irn_pkg;

	// fixed field widths
	localparam int PIX_W   = 16;
	localparam int COORD_W = 6;
	localparam int SIDE_W  = 7;
	localparam int TRIG_W  = 16;
	localparam int FRAC_W  = 14;
	localparam int QFRAC   = FRAC_W + 1;

	// datapath widths: 2x - w, one product, centered sum in Q.15
	localparam int DELTA_W = SIDE_W + 2;
	localparam int PROD_W  = TRIG_W + DELTA_W;
	localparam int SUM_W   = PROD_W + 2;

	// decoupling queue and front pipeline depth
	localparam int QUEUE_DEPTH  = 8;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FRONT_STAGES = 3;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);

	// register reset values
	localparam logic [TRIG_W-1:0] COS_RESET    = 16'h4000;
	localparam logic [TRIG_W-1:0] SIN_RESET    = 16'h0000;
	localparam logic [SIDE_W-1:0] WIDTH_RESET  = 7'd32;
	localparam logic [SIDE_W-1:0] HEIGHT_RESET = 7'd32;
	localparam logic [PIX_W-1:0]  FILL_RESET   = 16'hF81F;

	typedef enum logic [2:0] {
		CFG_COS,
		CFG_SIN,
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_FILL
	} cfg_index_t;

	typedef enum logic {
		MODE_WRITE,
		MODE_READ
	} mode_t;

	// one classified command between front and back
	typedef struct packed {
		logic               is_write;
		logic               outside;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [PIX_W-1:0]   data;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/irn_front.sv */
// irn_front: accepts input beats, maps requests through the rotation and classifies them
// depends on irn_pkg; feeds irn_queue
`default_nettype none

module irn_front #(
	parameter int MAX_SIDE = 64,
	parameter int AW       = 12
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  irn_pkg::mode_t                        mode,
	input  wire        [irn_pkg::COORD_W-1:0]     pixel_x,
	input  wire        [irn_pkg::COORD_W-1:0]     pixel_y,
	input  wire        [irn_pkg::PIX_W-1:0]       pixel_value,
	input  wire signed [irn_pkg::TRIG_W-1:0]      cos_term,
	input  wire signed [irn_pkg::TRIG_W-1:0]      sin_term,
	input  wire        [irn_pkg::SIDE_W-1:0]      side_w,
	input  wire        [irn_pkg::SIDE_W-1:0]      side_h,
	input  wire        [irn_pkg::QCNT_W-1:0]      q_count,
	output logic                                  push,
	output irn_pkg::cmd_t                         cmd,
	output logic       [AW-1:0]                   addr
);
	import irn_pkg::*;

	localparam int IW = $clog2(MAX_SIDE);

	logic                      valid_s1, valid_s2, valid_s3;
	mode_t                     mode_s1, mode_s2, mode_s3;
	logic [COORD_W-1:0]        x_s1, x_s2, x_s3;
	logic [COORD_W-1:0]        y_s1, y_s2, y_s3;
	logic [PIX_W-1:0]          data_s1, data_s2, data_s3;
	logic signed [DELTA_W-1:0] dx_s1, dy_s1;
	logic signed [PROD_W-1:0]  cdx_s2, sdy_s2, sdx_s2, cdy_s2;
	logic signed [SUM_W-1:0]   sx_s3, sy_s3;
	logic signed [SUM_W-1:0]   woff, hoff;
	logic signed [DELTA_W-1:0] dx_d, dy_d;
	logic [QCNT_W-1:0]         occupancy;
	logic                      accept, is_read, wr_ok, x_out, y_out;
	logic [IW-1:0]             xi, yi;

	// outside test along one axis, truncation toward zero
	function automatic logic axis_out(input logic signed [SUM_W-1:0] v,
			input logic [SIDE_W-1:0] side);
		logic small_neg;
		small_neg = (&v[SUM_W-1:QFRAC]) && (|v[QFRAC-1:0]);
		if (v[SUM_W-1]) begin
			axis_out = !small_neg || (side == '0);
		end else begin
			axis_out = v[SUM_W-2:QFRAC] >= (SUM_W-1-QFRAC)'(side);
		end
	endfunction

	function automatic logic [IW-1:0] axis_idx(input logic signed [SUM_W-1:0] v);
		axis_idx = v[SUM_W-1] ? '0 : v[QFRAC +: IW];
	endfunction

	// credit: queue plus stages in flight never exceed the queue depth
	assign occupancy = q_count + QCNT_W'(valid_s1) + QCNT_W'(valid_s2) + QCNT_W'(valid_s3);
	assign in_ready  = occupancy < QCNT_W'(QUEUE_DEPTH);
	assign accept    = in_valid && in_ready;

	assign dx_d = $signed({2'b00, pixel_x, 1'b0}) - $signed({2'b00, side_w});
	assign dy_d = $signed({2'b00, pixel_y, 1'b0}) - $signed({2'b00, side_h});
	assign woff = $signed({{(SUM_W-SIDE_W-FRAC_W){1'b0}}, side_w, {FRAC_W{1'b0}}});
	assign hoff = $signed({{(SUM_W-SIDE_W-FRAC_W){1'b0}}, side_h, {FRAC_W{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		x_s1    <= pixel_x;
		y_s1    <= pixel_y;
		data_s1 <= pixel_value;
		dx_s1   <= dx_d;
		dy_s1   <= dy_d;

		mode_s2 <= mode_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		data_s2 <= data_s1;
		cdx_s2  <= cos_term * dx_s1;
		sdy_s2  <= sin_term * dy_s1;
		sdx_s2  <= sin_term * dx_s1;
		cdy_s2  <= cos_term * dy_s1;

		mode_s3 <= mode_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		data_s3 <= data_s2;
		sx_s3   <= SUM_W'(cdx_s2) - SUM_W'(sdy_s2) + woff;
		sy_s3   <= SUM_W'(sdx_s2) + SUM_W'(cdy_s2) + hoff;
	end

	always_comb begin
		is_read = (mode_s3 == MODE_READ);
		wr_ok   = (int'(x_s3) < MAX_SIDE) && (int'(y_s3) < MAX_SIDE);
		x_out   = axis_out(sx_s3, side_w);
		y_out   = axis_out(sy_s3, side_h);
		xi      = is_read ? axis_idx(sx_s3) : IW'(x_s3);
		yi      = is_read ? axis_idx(sy_s3) : IW'(y_s3);
		addr    = AW'(yi) * AW'(MAX_SIDE) + AW'(xi);

		push         = valid_s3 && (is_read || wr_ok);
		cmd.is_write = !is_read;
		cmd.outside  = is_read && (x_out || y_out);
		cmd.x        = x_s3;
		cmd.y        = y_s3;
		cmd.data     = data_s3;
	end

endmodule

`default_nettype wire

/* rtl/irn_queue.sv */
// irn_queue: short fifo of classified commands between front and back
// depends on irn_pkg
`default_nettype none

module irn_queue #(
	parameter int AW = 12
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           push,
	input  irn_pkg::cmd_t                 push_cmd,
	input  wire  [AW-1:0]                 push_addr,
	input  wire                           pop,
	output logic                          empty,
	output irn_pkg::cmd_t                 head_cmd,
	output logic [AW-1:0]                 head_addr,
	output logic [irn_pkg::QCNT_W-1:0]    count
);
	import irn_pkg::*;

	cmd_t              cmd_q  [QUEUE_DEPTH];
	logic [AW-1:0]     addr_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty     = (count_q == '0);
	assign count     = count_q;
	assign head_cmd  = cmd_q[rd_ptr_q];
	assign head_addr = addr_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q]  <= push_cmd;
			addr_q[wr_ptr_q] <= push_addr;
		end
	end

endmodule

`default_nettype wire

/* rtl/irn_back.sv */
// irn_back: carries out commands against the sprite store and drives the result channel
// depends on irn_pkg; fed by irn_queue
`default_nettype none

module irn_back #(
	parameter int MAX_SIDE = 64,
	parameter int AW       = 12
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              empty,
	input  irn_pkg::cmd_t                    head_cmd,
	input  wire  [AW-1:0]                    head_addr,
	output logic                             pop,
	input  wire  [irn_pkg::PIX_W-1:0]        fill_color,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [irn_pkg::COORD_W-1:0]      out_x,
	output logic [irn_pkg::COORD_W-1:0]      out_y,
	output logic [irn_pkg::PIX_W-1:0]        out_value,
	output logic                             outside_flag
);
	import irn_pkg::*;

	localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;

	logic [PIX_W-1:0]   image_mem_q [MEM_DEPTH];
	logic               valid_s4, valid_s5;
	cmd_t               cmd_s4;
	logic [PIX_W-1:0]   rdata_s4, value_s5;
	logic [COORD_W-1:0] x_s5, y_s5;
	logic               outside_s5;
	logic               adv_s5, ready_s4, pop_read;

	assign adv_s5   = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || adv_s5;
	// writes never wait on the result side
	assign pop      = !empty && (head_cmd.is_write || ready_s4);
	assign pop_read = pop && !head_cmd.is_write;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_cmd.is_write) begin
				image_mem_q[head_addr] <= head_cmd.data;
			end else begin
				rdata_s4 <= image_mem_q[head_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (pop_read) begin
				valid_s4 <= 1'b1;
			end else if (adv_s5) begin
				valid_s4 <= 1'b0;
			end
			if (adv_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_read) begin
			cmd_s4 <= head_cmd;
		end
		if (adv_s5 && valid_s4) begin
			x_s5       <= cmd_s4.x;
			y_s5       <= cmd_s4.y;
			outside_s5 <= cmd_s4.outside;
			value_s5   <= cmd_s4.outside ? fill_color : rdata_s4;
		end
	end

	assign out_valid    = valid_s5;
	assign out_x        = x_s5;
	assign out_y        = y_s5;
	assign out_value    = value_s5;
	assign outside_flag = outside_s5;

endmodule

`default_nettype wire

/* rtl/image_rotate_nearest_unit.sv */
// image_rotate_nearest_unit: top level of the nearest-neighbor sprite rotator
// depends on irn_pkg, irn_front, irn_queue and irn_back
`default_nettype none

// The unit takes one beat per clock on the input channel while in_ready is high and
// returns one result beat per pixel request, in order, at one per clock sustained while
// out_ready is held high. Mode 0 beats store an RGB565 pixel in the on-chip sprite store
// (row * MAX_SIDE + column); mode 1 beats ask for a destination pixel, which is mapped
// back through the cosine/sine registers (Q1.14) about the sprite center, truncated
// toward zero, and sampled nearest-neighbor; a source point outside the sprite returns
// fill_color with outside_flag set. When nothing stalls, a request goes from its input
// beat to the result port through three front stages (capture, four 16x9 multipliers,
// sums), the command queue, the store read and the output register. The rate of one item
// per clock is set by the store's single write and single read port and the multiplier
// stage, each used once per item. The eight-entry command queue lets the front run ahead
// while the result side is stalled; in_ready drops once the queue plus the front stages
// hold eight beats. The store has no reset or clearing pass: a request that samples a
// never-written pixel returns an undefined value. Registers are written through the cfg
// channel, which is always ready, and are meant to change only while the unit is idle.
module image_rotate_nearest_unit #(
	parameter int MAX_SIDE = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration channel
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  irn_pkg::cfg_index_t               cfg_index,
	input  wire  [15:0]                       cfg_data,
	// input channel
	input  wire                               in_valid,
	output logic                              in_ready,
	input  irn_pkg::mode_t                    mode,
	input  wire  [irn_pkg::COORD_W-1:0]       pixel_x,
	input  wire  [irn_pkg::COORD_W-1:0]       pixel_y,
	input  wire  [irn_pkg::PIX_W-1:0]         pixel_value,
	// result channel
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [irn_pkg::COORD_W-1:0]       out_x,
	output logic [irn_pkg::COORD_W-1:0]       out_y,
	output logic [irn_pkg::PIX_W-1:0]         out_value,
	output logic                              outside_flag
);
	import irn_pkg::*;

	// sprite store address width
	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

	logic signed [TRIG_W-1:0] cos_q, sin_q;
	logic [SIDE_W-1:0]        width_q, height_q;
	logic [PIX_W-1:0]         fill_q;
	logic [SIDE_W-1:0]        side_w, side_h;

	// front to queue
	logic                     q_push;
	cmd_t                     q_push_cmd;
	logic [AW-1:0]            q_push_addr;
	// queue to back
	logic                     q_pop, q_empty;
	cmd_t                     q_head_cmd;
	logic [AW-1:0]            q_head_addr;
	logic [QCNT_W-1:0]        q_count;

	// configuration registers, always ready for a beat
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RESET;
			sin_q    <= SIN_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			fill_q   <= FILL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COS:    cos_q    <= cfg_data;
				CFG_SIN:    sin_q    <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[SIDE_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[SIDE_W-1:0];
				CFG_FILL:   fill_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// oversized sprite sides are limited to the store's side
	assign side_w = (int'(width_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : width_q;
	assign side_h = (int'(height_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : height_q;

	// front: accept, rotate, classify
	irn_front #(
		.MAX_SIDE (MAX_SIDE),
		.AW       (AW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.cos_term    (cos_q),
		.sin_term    (sin_q),
		.side_w      (side_w),
		.side_h      (side_h),
		.q_count     (q_count),
		.push        (q_push),
		.cmd         (q_push_cmd),
		.addr        (q_push_addr)
	);

	// command queue decoupling the two halves
	irn_queue #(
		.AW (AW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.push_addr (q_push_addr),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_cmd  (q_head_cmd),
		.head_addr (q_head_addr),
		.count     (q_count)
	);

	// back: sprite store and result register
	irn_back #(
		.MAX_SIDE (MAX_SIDE),
		.AW       (AW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.head_cmd     (q_head_cmd),
		.head_addr    (q_head_addr),
		.pop          (q_pop),
		.fill_color   (fill_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_value    (out_value),
		.outside_flag (outside_flag)
	);

`ifndef NO_ASSERTIONS
	// the front's credit scheme must keep the queue from overflowing
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)) || q_pop)
		else $error("command pushed into a full queue");

	// the back never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from an empty queue");

	// an empty queue always leaves room for a new input beat
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == '0) |-> in_ready)
		else $error("input stalled with an empty queue");
`endif

endmodule

`default_nettype wire
